// File: rtl/core/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared constants and types for the binary block deframer.
// ----------------------------------------------------------------------------
package sbf_pkg;

    // Sync pair that opens every binary block.
    localparam logic [7:0] SYNC_FIRST  = 8'h24;
    localparam logic [7:0] SYNC_SECOND = 8'h40;

    // Field widths.
    localparam int ID_W  = 13;
    localparam int LEN_W = 16;

    // Header bytes counted in the block length.
    localparam logic [LEN_W-1:0] HEADER_LEN = 16'd8;

    // One result as it leaves the framing logic.
    typedef struct packed {
        logic [ID_W-1:0]  block_id;
        logic [LEN_W-1:0] block_length;
        logic [7:0]       body_byte;
        logic [LEN_W-1:0] body_index;
        logic             last_of_block;
        logic             empty_block;
    } t_result;

endpackage

// File: rtl/core/sbf_frame_fsm.sv
// ----------------------------------------------------------------------------
// sbf_frame_fsm
// Byte-wise framing state machine: tracks sync, header and body, and forms
// the result for the byte being taken.
// ----------------------------------------------------------------------------
module sbf_frame_fsm
    import sbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [8:0] {
        S_SYNC1 = 9'b000000001,
        S_SYNC2 = 9'b000000010,
        S_CRC0  = 9'b000000100,
        S_CRC1  = 9'b000001000,
        S_ID0   = 9'b000010000,
        S_ID1   = 9'b000100000,
        S_LEN0  = 9'b001000000,
        S_LEN1  = 9'b010000000,
        S_BODY  = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_id_lo, n_id_lo;
    logic [ID_W-1:0]  r_block_id, n_block_id;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [LEN_W-1:0] r_length, n_length;
    logic [LEN_W-1:0] r_count, n_count;

    logic [LEN_W-1:0] full_length;
    logic [LEN_W:0]   next_count;
    logic [LEN_W:0]   body_len;
    logic             body_last;

    assign full_length = {i_rx_byte, r_len_lo};
    assign next_count  = {1'b0, r_count} + {{LEN_W{1'b0}}, 1'b1};
    assign body_len    = {1'b0, r_length} - {1'b0, HEADER_LEN};
    assign body_last   = (next_count >= body_len);

    // Next state and result for the current byte.
    always_comb begin
        n_state     = r_state;
        n_id_lo     = r_id_lo;
        n_block_id  = r_block_id;
        n_len_lo    = r_len_lo;
        n_length    = r_length;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '{block_id: r_block_id, block_length: r_length,
                        body_byte: 8'd0, body_index: '0,
                        last_of_block: 1'b1, empty_block: 1'b1};
        case (r_state)
            S_SYNC1: begin
                if (i_rx_byte == SYNC_FIRST) n_state = S_SYNC2;
            end
            S_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) n_state = S_CRC0;
                else if (i_rx_byte == SYNC_FIRST) n_state = S_SYNC2;
                else n_state = S_SYNC1;
            end
            S_CRC0: n_state = S_CRC1;
            S_CRC1: n_state = S_ID0;
            S_ID0: begin
                n_id_lo = i_rx_byte;
                n_state = S_ID1;
            end
            S_ID1: begin
                // Revision bits in the top of the ID are dropped.
                n_block_id = {i_rx_byte[ID_W-9:0], r_id_lo};
                n_state    = S_LEN0;
            end
            S_LEN0: begin
                n_len_lo = i_rx_byte;
                n_state  = S_LEN1;
            end
            S_LEN1: begin
                n_length = full_length;
                n_count  = '0;
                if (full_length <= HEADER_LEN) begin
                    // Header-only block gives a single empty result.
                    o_res_valid        = 1'b1;
                    o_res.block_length = full_length;
                    n_state            = S_SYNC1;
                end else begin
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                o_res_valid         = 1'b1;
                o_res.body_byte     = i_rx_byte;
                o_res.body_index    = r_count;
                o_res.last_of_block = body_last;
                o_res.empty_block   = 1'b0;
                n_count             = next_count[LEN_W-1:0];
                if (body_last) n_state = S_SYNC1;
            end
            default: n_state = S_SYNC1;
        endcase
    end

    // State registers advance only when a byte is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SYNC1;
            r_id_lo    <= '0;
            r_block_id <= '0;
            r_len_lo   <= '0;
            r_length   <= '0;
            r_count    <= '0;
        end else if (i_take) begin
            r_state    <= n_state;
            r_id_lo    <= n_id_lo;
            r_block_id <= n_block_id;
            r_len_lo   <= n_len_lo;
            r_length   <= n_length;
            r_count    <= n_count;
        end
    end

endmodule

// File: rtl/core/sbf_block_deframer.sv
// ----------------------------------------------------------------------------
// sbf_block_deframer
// Finds sync-framed binary blocks in a received byte stream and streams out
// their body bytes tagged with block ID, length and index.
// ----------------------------------------------------------------------------
// The deframer takes one byte per clock cycle and gives at most one result
// per byte, in the cycle after the byte is taken, from a single output
// register; the header is parsed by a one-hot state machine and the CRC is
// skipped without checking. A new byte is taken in every cycle in which the
// output register is empty or its result is being taken at the same edge,
// so throughput is one byte per cycle when the output is not stalled.
// ----------------------------------------------------------------------------
module sbf_block_deframer
    import sbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ID_W-1:0]   o_block_id,
    output logic [LEN_W-1:0]  o_block_length,
    output logic [7:0]        o_body_byte,
    output logic [LEN_W-1:0]  o_body_index,
    output logic              o_last_of_block,
    output logic              o_empty_block
);

    logic    r_out_valid;
    t_result r_out;
    logic    take;
    logic    res_valid;
    t_result res;

    // Input transaction goes ahead when the output register can be refilled.
    assign o_stall = r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    sbf_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_block_id      = r_out.block_id;
    assign o_block_length  = r_out.block_length;
    assign o_body_byte     = r_out.body_byte;
    assign o_body_index    = r_out.body_index;
    assign o_last_of_block = r_out.last_of_block;
    assign o_empty_block   = r_out.empty_block;

endmodule

// File: dv/sbf_block_deframer_tb.sv
// ----------------------------------------------------------------------------
// sbf_block_deframer_tb
// Self-checking bench for the binary block deframer. A byte stream of
// noise, broken sync pairs and framed blocks of random content is driven
// into the deframer with random gaps. Every taken byte runs through a
// local model of the framing logic. Each result transaction is compared
// field by field with the oldest predicted result. The output side is
// stalled at random.
// ----------------------------------------------------------------------------
module sbf_block_deframer_tb;
    import sbf_pkg::*;

    // Framing phases of the local model.
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_CRC0  = 4'd2,
        PH_CRC1  = 4'd3,
        PH_ID0   = 4'd4,
        PH_ID1   = 4'd5,
        PH_LEN0  = 4'd6,
        PH_LEN1  = 4'd7,
        PH_BODY  = 4'd8
    } t_phase;

    localparam logic [15:0] ID_MASK    = 16'h1FFF;
    localparam int          RAND_BYTES = 1050;
    localparam int          IDLE_LIMIT = 1000;
    localparam int          TAIL_WAIT  = 8;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [7:0]       i_rx_byte = 8'd0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [ID_W-1:0]  o_block_id;
    logic [LEN_W-1:0] o_block_length;
    logic [7:0]       o_body_byte;
    logic [LEN_W-1:0] o_body_index;
    logic             o_last_of_block;
    logic             o_empty_block;

    // Bytes still to be sent and results still to arrive.
    logic [7:0] rx_stream[$];
    t_result    pending_results[$];

    // Local copy of the deframer state.
    t_phase          phase = PH_HUNT;
    logic [ID_W-1:0] held_id = '0;
    logic [15:0]     held_len = '0;
    logic [15:0]     body_count = '0;

    int      error_count = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      idle_cycles = 0;
    bit      send_calm = 1'b0;
    bit      stall_calm = 1'b0;
    t_result predicted;
    t_result wanted;

    sbf_block_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_block_id     (o_block_id),
        .o_block_length (o_block_length),
        .o_body_byte    (o_body_byte),
        .o_body_index   (o_body_index),
        .o_last_of_block(o_last_of_block),
        .o_empty_block  (o_empty_block)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Appends one byte to the end of the stream.
    function automatic void put_byte(input logic [7:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endfunction

    // Appends one predicted result to the end of the expected list.
    function automatic void put_result(input t_result res);
        pending_results.insert(pending_results.size(), res);
    endfunction

    // Advances the local framing state by one byte; returns 1 with the
    // expected result when the byte produces one.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result res);
        int  body_len;
        int  next_count;
        bit  last;
        res = '0;
        case (phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                // A repeated first sync byte keeps the wait for the second.
                if (b == SYNC_SECOND) phase = PH_CRC0;
                else if (b == SYNC_FIRST) phase = PH_SYNC2;
                else phase = PH_HUNT;
            end
            PH_CRC0: phase = PH_CRC1;
            PH_CRC1: phase = PH_ID0;
            PH_ID0: begin
                held_id = {5'd0, b};
                phase = PH_ID1;
            end
            PH_ID1: begin
                held_id = ID_W'({b, held_id[7:0]} & ID_MASK);
                phase = PH_LEN0;
            end
            PH_LEN0: begin
                held_len = {8'd0, b};
                phase = PH_LEN1;
            end
            PH_LEN1: begin
                held_len = {b, held_len[7:0]};
                body_count = '0;
                if (held_len <= HEADER_LEN) begin
                    // Header-only block: one empty result, then back to hunting.
                    res.block_id = held_id;
                    res.block_length = held_len;
                    res.last_of_block = 1'b1;
                    res.empty_block = 1'b1;
                    phase = PH_HUNT;
                    return 1'b1;
                end
                phase = PH_BODY;
            end
            PH_BODY: begin
                body_len = int'(held_len) - int'(HEADER_LEN);
                next_count = int'(body_count) + 1;
                last = (next_count >= body_len);
                res.block_id = held_id;
                res.block_length = held_len;
                res.body_byte = b;
                res.body_index = body_count;
                res.last_of_block = last;
                body_count = 16'(next_count);
                if (last) phase = PH_HUNT;
                return 1'b1;
            end
            default: phase = PH_HUNT;
        endcase
        return 1'b0;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Queues a well-formed block with random CRC and body.
    task automatic queue_block(input logic [15:0] id, input logic [15:0] len);
        int n;
        put_byte(SYNC_FIRST);
        put_byte(SYNC_SECOND);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(id[7:0]);
        put_byte(id[15:8]);
        put_byte(len[7:0]);
        put_byte(len[15:8]);
        n = int'(len) - int'(HEADER_LEN);
        for (int k = 0; k < n; k++) put_byte(8'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Driver: presents the queued bytes and models each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (deframe_byte(i_rx_byte, predicted)) put_result(predicted);
            end
            if (!i_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (rx_stream.size() != 0) begin
                    i_valid <= 1'b1;
                    i_rx_byte <= rx_stream.pop_front();
                    if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
                    send_gap = send_calm ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transaction and drives the output stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, block_id %0d index %0d",
                             $time, o_block_id, o_body_index);
                    error_count++;
                end else begin
                    wanted = pending_results.pop_front();
                    check_field("block_id", wanted.block_id, o_block_id);
                    check_field("block_length", wanted.block_length, o_block_length);
                    check_field("body_byte", wanted.body_byte, o_body_byte);
                    check_field("body_index", wanted.body_index, o_body_index);
                    check_field("last_of_block", wanted.last_of_block, o_last_of_block);
                    check_field("empty_block", wanted.empty_block, o_empty_block);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 299) == 0) stall_calm = !stall_calm;
                stall_left = stall_calm ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("sbf_block_deframer verification failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int r;
        int count;
        int len;
        logic [7:0] b;

        // Directed: noise, a sync pair broken off, a repeated first sync byte
        // leading into a header-only block with every ID bit set and the
        // revision bits to be dropped, then a two-byte body with extreme values.
        rx_stream = '{8'h00,
                      SYNC_FIRST, 8'h11,
                      SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, 8'h00, 8'hFF,
                      8'hFF, 8'hFF, 8'h08, 8'h00,
                      SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'h00,
                      8'h00, 8'h00, 8'h0A, 8'h00, 8'h00, 8'hFF};

        // Random: mostly well-formed blocks, some noise and broken syncs.
        count = rx_stream.size();
        while (rx_stream.size() < count + RAND_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                r = $urandom_range(0, 99);
                if (r < 25) len = $urandom_range(0, 8);
                else if (r < 90) len = $urandom_range(9, 40);
                else len = $urandom_range(41, 300);
                queue_block(16'($urandom), 16'(len));
            end else if (r < 85) begin
                // Noise never holds a first sync byte, so it leaves no partial frame.
                repeat ($urandom_range(1, 6)) begin
                    b = 8'($urandom);
                    if (b == SYNC_FIRST) b = b ^ 8'h01;
                    put_byte(b);
                end
            end else begin
                repeat ($urandom_range(1, 3)) put_byte(SYNC_FIRST);
                b = 8'($urandom);
                if (b == SYNC_SECOND || b == SYNC_FIRST) b = b ^ 8'h01;
                put_byte(b);
            end
        end

        // A block header of the largest length reaches the top length bits;
        // the stream ends a few bytes into its body.
        put_byte(SYNC_FIRST);
        put_byte(SYNC_SECOND);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(8'($urandom));
        put_byte(8'hFF);
        put_byte(8'hFF);
        repeat (16) put_byte(8'($urandom));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_stream.size() != 0 || i_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sbf_block_deframer verification clean");
        end else begin
            $display("sbf_block_deframer verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sbf_pkg.sv
rtl/core/sbf_frame_fsm.sv
rtl/core/sbf_block_deframer.sv
dv/sbf_block_deframer_tb.sv
